>>> rtl/core/portal_frustum_clip_macros.svh
// Assertion macros shared by the portal frustum clip RTL.
`ifndef PORTAL_FRUSTUM_CLIP_MACROS_SVH
`define PORTAL_FRUSTUM_CLIP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFC_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/core/pfc_pkg.sv
// Package with the types, sizes and codes of the portal frustum clip block.
package pfc_pkg;

	localparam int MAX_PLANES = 16;
	localparam int MAX_VERTS  = 32;
	localparam int PCNT_W     = $clog2(MAX_PLANES + 1);
	localparam int VCNT_W     = $clog2(MAX_VERTS + 1);
	localparam int PIDX_W     = $clog2(MAX_PLANES);
	localparam int VIDX_W     = $clog2(MAX_VERTS);
	localparam int IDX_W      = (PCNT_W > VCNT_W) ? PCNT_W : VCNT_W;
	localparam int MAG_W      = 49;
	localparam int ACC_W      = 68;
	localparam int QUO_W      = 18;

	typedef enum logic [1:0] {
		CMD_CLEAR      = 2'd0,
		CMD_LOAD_PLANE = 2'd1,
		CMD_LOAD_VERT  = 2'd2,
		CMD_RUN        = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_PLANE  = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
		logic [31:0] d;
		logic        side;
		logic        last;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TEST_PL,
		S_TEST_VT,
		S_TEST_MUL,
		S_REJECT,
		S_CARRY,
		S_CARRY_PUT,
		S_EDGE_A,
		S_EDGE_B,
		S_EDGE_C,
		S_CROSS,
		S_CZERO,
		S_NORM,
		S_SQUARE,
		S_SQRT,
		S_DIV_INIT,
		S_DIV,
		S_DOT,
		S_SIDE_PUT,
		S_FINISH
	} state_t;

endpackage

>>> rtl/core/portal_frustum_clip.sv
// Portal frustum clip: stores planes and portal vertices and narrows the frustum on a run request.
//
// Requests arrive on the s_axis channel: tuser carries the command (clear, load a
// plane, load a vertex, run with the eye point) and tdata the coordinates. Result
// items leave on the m_axis channel with tuser holding status and the side-plane
// flag and tlast marking the final result of a run.
// Clear and load requests return nothing; the block is ready again in the next
// cycle. A run is worked by one shared 32 by 32 multiplier under a sequencer.
// It runs the rejection test over plane and vertex pairs, carries each plane
// and then builds side planes from the portal edges, skipping edges whose cross
// product is zero: six multiplies for the cross product, a one-bit-per-cycle
// normalizing shift, three squares, a 32-step square root, three 18-step
// divisions and three multiplies for the offset. The block accepts no request
// while a run is in work.
// Reset clears both counts and drops any result not yet taken; the stores need
// no clearing. When the receiver stalls, the finished result waits in the output
// register while one more result is held back, and the run pauses until the
// output register is taken.
`include "portal_frustum_clip_macros.svh"

module portal_frustum_clip (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // coord_x, coord_y, coord_z, plane_offset
	input  logic [1:0]   s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // normal_x, normal_y, normal_z, out_offset
	output logic [2:0]   m_axis_tuser,  // status, is_side_plane
	output logic         m_axis_tlast
);
	import pfc_pkg::*;

	state_t state_q, state_d;

	logic [127:0] plane_store_q [MAX_PLANES];
	logic [95:0]  vertex_store_q [MAX_VERTS];
	logic [127:0] plane_rd_q;
	logic [95:0]  vert_rd_q;
	logic [PIDX_W-1:0] plane_addr;
	logic [VIDX_W-1:0] vert_addr;

	logic [PCNT_W-1:0] pcnt_q, n_q;
	logic [VCNT_W-1:0] vcnt_q;
	logic [IDX_W-1:0]  i_q, j_q, i_next;
	logic [2:0]        k_q;
	logic [1:0]        comp_q;
	logic [4:0]        cnt_q;

	logic signed [31:0] ex_q, ey_q, ez_q;
	logic signed [32:0] dax_q, day_q, daz_q;
	logic signed [31:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [32:0] dbx, dby, dbz;
	logic               wide;
	logic signed [MAG_W-1:0] cx_q, cy_q, cz_q, fcr;
	logic [MAG_W-1:0]   m0_q, m1_q, m2_q, mmax, mcomp;
	logic [2:0]         sgn_q;
	logic [63:0]        sum_q, sqv_q, root_q, bit_q, sq_t;
	logic [31:0]        len;
	logic [47:0]        num;
	logic [31:0]        rem_q;
	logic [QUO_W-1:0]   dv_q, quo;
	logic [32:0]        div_t;
	logic               div_ge;
	logic signed [31:0] nx_q, ny_q, nz_q, nn_new;
	logic signed [ACC_W-1:0] acc_q, acc_sum, dd_full;
	logic signed [31:0] dd;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_q;

	logic signed [31:0] p_nx, p_ny, p_nz, p_d, v_x, v_y, v_z;
	logic               s_acc, out_free, put_ok, out_load, vtx_in;
	res_t               out_data, pend_q, m_q, pend_new;
	logic               pend_v_q, m_valid_q;

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign put_ok   = !pend_v_q || out_free;

	assign p_nx = plane_rd_q[31:0];
	assign p_ny = plane_rd_q[63:32];
	assign p_nz = plane_rd_q[95:64];
	assign p_d  = plane_rd_q[127:96];
	assign v_x  = vert_rd_q[31:0];
	assign v_y  = vert_rd_q[63:32];
	assign v_z  = vert_rd_q[95:64];

	assign i_next  = (i_q + IDX_W'(1) == IDX_W'(vcnt_q)) ? '0 : i_q + IDX_W'(1);
	assign acc_sum = acc_q + ACC_W'(mul_q);
	assign vtx_in  = !acc_sum[ACC_W-1];

	assign dbx  = {v_x[31], v_x} - {ex_q[31], ex_q};
	assign dby  = {v_y[31], v_y} - {ey_q[31], ey_q};
	assign dbz  = {v_z[31], v_z} - {ez_q[31], ez_q};
	assign wide = (dax_q[32] != dax_q[31]) || (day_q[32] != day_q[31]) ||
		(daz_q[32] != daz_q[31]) || (dbx[32] != dbx[31]) ||
		(dby[32] != dby[31]) || (dbz[32] != dbz[31]);
	assign fcr  = {mul_q[63], mul_q[63:16]};

	assign mmax = (m0_q >= m1_q && m0_q >= m2_q) ? m0_q : ((m1_q >= m2_q) ? m1_q : m2_q);
	assign sq_t = root_q + bit_q;
	assign len  = root_q[31:0];

	always_comb begin
		case (comp_q)
			2'd0:    mcomp = m0_q;
			2'd1:    mcomp = m1_q;
			default: mcomp = m2_q;
		endcase
	end
	assign num    = {2'b0, mcomp[29:0], 16'b0} + {17'b0, len[31:1]};
	assign div_t  = {rem_q, dv_q[QUO_W-1]};
	assign div_ge = div_t >= {1'b0, len};
	assign quo    = {dv_q[QUO_W-2:0], div_ge};
	assign nn_new = sgn_q[comp_q] ? -$signed({14'b0, quo}) : $signed({14'b0, quo});

	assign dd_full = (acc_q + ACC_W'(32768)) >>> 16;
	always_comb begin
		if (dd_full[ACC_W-1:31] == '0 || dd_full[ACC_W-1:31] == '1)
			dd = dd_full[31:0];
		else if (dd_full[ACC_W-1])
			dd = 32'sh8000_0000;
		else
			dd = 32'sh7fff_ffff;
	end

	always_comb begin
		plane_addr = i_q[PIDX_W-1:0];
		case (state_q)
			S_EDGE_B: vert_addr = i_next[VIDX_W-1:0];
			S_EDGE_A: vert_addr = i_q[VIDX_W-1:0];
			default:  vert_addr = j_q[VIDX_W-1:0];
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TEST_MUL: begin
				case (k_q)
					3'd0:    begin mul_a = p_nx; mul_b = v_x; end
					3'd1:    begin mul_a = p_ny; mul_b = v_y; end
					default: begin mul_a = p_nz; mul_b = v_z; end
				endcase
			end
			S_CROSS: begin
				case (k_q)
					3'd0:    begin mul_a = ay_q; mul_b = bz_q; end
					3'd1:    begin mul_a = az_q; mul_b = by_q; end
					3'd2:    begin mul_a = az_q; mul_b = bx_q; end
					3'd3:    begin mul_a = ax_q; mul_b = bz_q; end
					3'd4:    begin mul_a = ax_q; mul_b = by_q; end
					default: begin mul_a = ay_q; mul_b = bx_q; end
				endcase
			end
			S_SQUARE: begin
				case (k_q)
					3'd0:    begin mul_a = {2'b0, m0_q[29:0]}; mul_b = {2'b0, m0_q[29:0]}; end
					3'd1:    begin mul_a = {2'b0, m1_q[29:0]}; mul_b = {2'b0, m1_q[29:0]}; end
					default: begin mul_a = {2'b0, m2_q[29:0]}; mul_b = {2'b0, m2_q[29:0]}; end
				endcase
			end
			S_DOT: begin
				case (k_q)
					3'd0:    begin mul_a = nx_q; mul_b = ex_q; end
					3'd1:    begin mul_a = ny_q; mul_b = ey_q; end
					default: begin mul_a = nz_q; mul_b = ez_q; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_data      = pend_q;
		out_data.last = 1'b0;
		pend_new      = '0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_acc && cmd_t'(s_axis_tuser) == CMD_RUN)
					state_d = S_TEST_PL;
			end
			S_TEST_PL: begin
				state_d = (i_q == IDX_W'(pcnt_q)) ? S_CARRY : S_TEST_VT;
			end
			S_TEST_VT: begin
				state_d = (j_q == IDX_W'(vcnt_q)) ? S_REJECT : S_TEST_MUL;
			end
			S_TEST_MUL: begin
				if (k_q == 3'd3)
					state_d = vtx_in ? S_TEST_PL : S_TEST_VT;
			end
			S_REJECT: begin
				out_data        = '0;
				out_data.status = ST_REJECT;
				out_data.last   = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_CARRY: begin
				if (i_q == IDX_W'(pcnt_q))
					state_d = (vcnt_q >= VCNT_W'(3)) ? S_EDGE_A : S_FINISH;
				else
					state_d = S_CARRY_PUT;
			end
			S_CARRY_PUT: begin
				pend_new.status = ST_PLANE;
				pend_new.nx     = p_nx;
				pend_new.ny     = p_ny;
				pend_new.nz     = p_nz;
				pend_new.d      = p_d;
				if (put_ok) begin
					out_load = pend_v_q;
					state_d  = S_CARRY;
				end
			end
			S_EDGE_A: begin
				if (i_q == IDX_W'(vcnt_q) || n_q == PCNT_W'(MAX_PLANES))
					state_d = S_FINISH;
				else
					state_d = S_EDGE_B;
			end
			S_EDGE_B: state_d = S_EDGE_C;
			S_EDGE_C: state_d = S_CROSS;
			S_CROSS: begin
				if (k_q == 3'd6)
					state_d = S_CZERO;
			end
			S_CZERO: begin
				state_d = (cx_q == '0 && cy_q == '0 && cz_q == '0) ? S_EDGE_A : S_NORM;
			end
			S_NORM: begin
				if (mmax[MAG_W-1:30] == '0 && mmax[29])
					state_d = S_SQUARE;
			end
			S_SQUARE: begin
				if (k_q == 3'd3)
					state_d = S_SQRT;
			end
			S_SQRT: begin
				if (bit_q == 64'd1)
					state_d = S_DIV_INIT;
			end
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == '0)
					state_d = (comp_q == 2'd2) ? S_DOT : S_DIV_INIT;
			end
			S_DOT: begin
				if (k_q == 3'd3)
					state_d = S_SIDE_PUT;
			end
			S_SIDE_PUT: begin
				pend_new.status = ST_PLANE;
				pend_new.nx     = nx_q;
				pend_new.ny     = ny_q;
				pend_new.nz     = nz_q;
				pend_new.d      = dd;
				pend_new.side   = 1'b1;
				if (put_ok) begin
					out_load = pend_v_q;
					state_d  = S_EDGE_A;
				end
			end
			S_FINISH: begin
				if (pend_v_q) begin
					out_data      = pend_q;
					out_data.last = 1'b1;
				end else begin
					out_data        = '0;
					out_data.status = ST_EMPTY;
					out_data.last   = 1'b1;
				end
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		plane_rd_q <= plane_store_q[plane_addr];
		vert_rd_q  <= vertex_store_q[vert_addr];
		if (s_acc && cmd_t'(s_axis_tuser) == CMD_LOAD_PLANE && pcnt_q < PCNT_W'(MAX_PLANES))
			plane_store_q[pcnt_q[PIDX_W-1:0]] <= s_axis_tdata;
		if (s_acc && cmd_t'(s_axis_tuser) == CMD_LOAD_VERT && vcnt_q < VCNT_W'(MAX_VERTS))
			vertex_store_q[vcnt_q[VIDX_W-1:0]] <= s_axis_tdata[95:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q    <= '0;
			vcnt_q    <= '0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			comp_q    <= '0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			k_q <= (state_d != state_q) ? 3'd0 : k_q + 3'd1;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						case (cmd_t'(s_axis_tuser))
							CMD_CLEAR: begin
								pcnt_q <= '0;
								vcnt_q <= '0;
							end
							CMD_LOAD_PLANE: begin
								if (pcnt_q < PCNT_W'(MAX_PLANES))
									pcnt_q <= pcnt_q + PCNT_W'(1);
							end
							CMD_LOAD_VERT: begin
								if (vcnt_q < VCNT_W'(MAX_VERTS))
									vcnt_q <= vcnt_q + VCNT_W'(1);
							end
							default: begin
								i_q      <= '0;
								n_q      <= '0;
								pend_v_q <= 1'b0;
							end
						endcase
					end
				end
				S_TEST_PL: begin
					j_q <= '0;
					if (i_q == IDX_W'(pcnt_q))
						i_q <= '0;
				end
				S_TEST_MUL: begin
					if (k_q == 3'd3) begin
						if (vtx_in)
							i_q <= i_q + IDX_W'(1);
						else
							j_q <= j_q + IDX_W'(1);
					end
				end
				S_CARRY: begin
					if (i_q == IDX_W'(pcnt_q))
						i_q <= '0;
				end
				S_CARRY_PUT, S_SIDE_PUT: begin
					if (put_ok) begin
						pend_v_q <= 1'b1;
						i_q      <= i_q + IDX_W'(1);
						n_q      <= n_q + PCNT_W'(1);
					end
				end
				S_CZERO: begin
					comp_q <= '0;
					if (state_d == S_EDGE_A)
						i_q <= i_q + IDX_W'(1);
				end
				S_DIV_INIT: cnt_q <= 5'(QUO_W - 1);
				S_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						comp_q <= comp_q + 2'd1;
				end
				S_FINISH: begin
					if (out_free)
						pend_v_q <= 1'b0;
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (out_load)
			m_q <= out_data;
		case (state_q)
			S_IDLE: begin
				ex_q <= s_axis_tdata[31:0];
				ey_q <= s_axis_tdata[63:32];
				ez_q <= s_axis_tdata[95:64];
			end
			S_TEST_MUL: begin
				if (k_q == 3'd0)
					acc_q <= -(ACC_W'(p_d) <<< 16);
				else
					acc_q <= acc_sum;
			end
			S_CARRY_PUT, S_SIDE_PUT: begin
				if (put_ok)
					pend_q <= pend_new;
			end
			S_EDGE_B: begin
				dax_q <= {v_x[31], v_x} - {ex_q[31], ex_q};
				day_q <= {v_y[31], v_y} - {ey_q[31], ey_q};
				daz_q <= {v_z[31], v_z} - {ez_q[31], ez_q};
			end
			S_EDGE_C: begin
				if (wide) begin
					ax_q <= dax_q[32:1];
					ay_q <= day_q[32:1];
					az_q <= daz_q[32:1];
					bx_q <= dbx[32:1];
					by_q <= dby[32:1];
					bz_q <= dbz[32:1];
				end else begin
					ax_q <= dax_q[31:0];
					ay_q <= day_q[31:0];
					az_q <= daz_q[31:0];
					bx_q <= dbx[31:0];
					by_q <= dby[31:0];
					bz_q <= dbz[31:0];
				end
			end
			S_CROSS: begin
				case (k_q)
					3'd1:    cx_q <= fcr;
					3'd2:    cx_q <= cx_q - fcr;
					3'd3:    cy_q <= fcr;
					3'd4:    cy_q <= cy_q - fcr;
					3'd5:    cz_q <= fcr;
					3'd6:    cz_q <= cz_q - fcr;
					default: cx_q <= cx_q;
				endcase
			end
			S_CZERO: begin
				sgn_q <= {cz_q[MAG_W-1], cy_q[MAG_W-1], cx_q[MAG_W-1]};
				m0_q  <= cx_q[MAG_W-1] ? MAG_W'(-cx_q) : MAG_W'(cx_q);
				m1_q  <= cy_q[MAG_W-1] ? MAG_W'(-cy_q) : MAG_W'(cy_q);
				m2_q  <= cz_q[MAG_W-1] ? MAG_W'(-cz_q) : MAG_W'(cz_q);
			end
			S_NORM: begin
				if (mmax[MAG_W-1:30] != '0) begin
					m0_q <= m0_q >> 1;
					m1_q <= m1_q >> 1;
					m2_q <= m2_q >> 1;
				end else if (!mmax[29]) begin
					m0_q <= m0_q << 1;
					m1_q <= m1_q << 1;
					m2_q <= m2_q << 1;
				end
			end
			S_SQUARE: begin
				case (k_q)
					3'd0:    sum_q <= '0;
					3'd3: begin
						sqv_q  <= sum_q + 64'(mul_q);
						root_q <= '0;
						bit_q  <= 64'd1 << 62;
					end
					default: sum_q <= sum_q + 64'(mul_q);
				endcase
			end
			S_SQRT: begin
				if (sqv_q >= sq_t) begin
					sqv_q  <= sqv_q - sq_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV_INIT: begin
				rem_q <= {2'b0, num[47:QUO_W]};
				dv_q  <= num[QUO_W-1:0];
			end
			S_DIV: begin
				rem_q <= div_ge ? 32'(div_t - {1'b0, len}) : div_t[31:0];
				dv_q  <= quo;
				if (cnt_q == '0) begin
					case (comp_q)
						2'd0:    nx_q <= nn_new;
						2'd1:    ny_q <= nn_new;
						default: nz_q <= nn_new;
					endcase
				end
			end
			S_DOT: begin
				if (k_q == 3'd1)
					acc_q <= ACC_W'(mul_q);
				else if (k_q != 3'd0)
					acc_q <= acc_sum;
			end
			default: begin
				sgn_q <= sgn_q;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_q.d, m_q.nz, m_q.ny, m_q.nx};
	assign m_axis_tuser  = {m_q.side, m_q.status};
	assign m_axis_tlast  = m_q.last;

	`PFC_ASSERT_IMPLY(a_counts_in_range, 1'b1,
		pcnt_q <= PCNT_W'(MAX_PLANES) && vcnt_q <= VCNT_W'(MAX_VERTS) &&
		n_q <= PCNT_W'(MAX_PLANES), "store or emit count beyond capacity")
	`PFC_ASSERT_IMPLY(a_norm_window, state_q == S_SQUARE,
		mmax[MAG_W-1:30] == '0 && mmax[29], "normalized magnitude outside window")
	`PFC_ASSERT_IMPLY(a_len_floor, state_q == S_DIV,
		len[31:29] != 3'd0, "normalizing length below lower bound")
	`PFC_ASSERT_NEXT(a_run_ends_last, state_q == S_FINISH && out_free,
		m_axis_tvalid && m_axis_tlast, "run finished without a final result")

endmodule

>>> test/tb_portal_frustum_clip.sv
// Self-checking testbench for portal_frustum_clip: directed jobs, then random jobs, checked against a predictor.
module tb_portal_frustum_clip;
	timeunit 1ns;
	timeprecision 1ps;
	import pfc_pkg::*;

	localparam int ONE = 65536;
	localparam int IMIN = 32'sh8000_0000;
	localparam int IMAX = 32'sh7fff_ffff;
	localparam int ITEM_GOAL = 460;
	localparam longint LIMIT = 30000000;

	typedef struct {
		int nx, ny, nz, d;
	} plane_t;
	typedef struct {
		int x, y, z;
	} vert_t;
	typedef struct {
		status_t status;
		int nx, ny, nz, d;
		bit side, last;
	} clip_res_t;
	typedef struct {
		cmd_t cmd;
		int x, y, z, w;
		bit typed;
		status_t st;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [127:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	plane_t frustum[MAX_PLANES];
	vert_t portal[MAX_VERTS];
	int n_planes = 0;
	int n_verts = 0;
	clip_res_t pending[$];
	row_t rows[$];
	int errors = 0;
	int sent = 0;
	int burst_left = 0;
	int n_runs = 0;
	int n_results = 0;
	int n_sides = 0;
	int n_rejects = 0;
	int n_empty = 0;
	longint cycles = 0;
	int stall_mode = 0;
	int stall_left = 0;

	portal_frustum_clip i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic bit vertex_inside(plane_t p, vert_t v);
		longint prod[3];
		longint q, qs, rs, e;
		qs = 0;
		rs = 0;
		prod[0] = longint'(p.nx) * longint'(v.x);
		prod[1] = longint'(p.ny) * longint'(v.y);
		prod[2] = longint'(p.nz) * longint'(v.z);
		for (int k = 0; k < 3; k++) begin
			q = prod[k] >>> 2;
			qs += q;
			rs += prod[k] - q * 4;
		end
		e = qs - longint'(p.d) * 16384;
		return e >= -(rs / 4);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit wide(longint a);
		return a < longint'(IMIN) || a > longint'(IMAX);
	endfunction

	function automatic clip_res_t side_plane(vert_t v0, vert_t v1, int ex, int ey, int ez,
			output bit skip);
		longint a[3], b[3], c[3];
		longint unsigned m[3];
		longint unsigned mx, sum, len, q;
		int nn[3];
		longint dd;
		clip_res_t r;
		bit w;
		a[0] = longint'(v0.x) - ex; a[1] = longint'(v0.y) - ey; a[2] = longint'(v0.z) - ez;
		b[0] = longint'(v1.x) - ex; b[1] = longint'(v1.y) - ey; b[2] = longint'(v1.z) - ez;
		w = 0;
		for (int k = 0; k < 3; k++)
			if (wide(a[k]) || wide(b[k])) w = 1;
		if (w) begin
			for (int k = 0; k < 3; k++) begin
				a[k] = a[k] >>> 1;
				b[k] = b[k] >>> 1;
			end
		end
		c[0] = ((a[1] * b[2]) >>> 16) - ((a[2] * b[1]) >>> 16);
		c[1] = ((a[2] * b[0]) >>> 16) - ((a[0] * b[2]) >>> 16);
		c[2] = ((a[0] * b[1]) >>> 16) - ((a[1] * b[0]) >>> 16);
		skip = (c[0] == 0 && c[1] == 0 && c[2] == 0);
		r = '{ST_PLANE, 0, 0, 0, 0, 1, 0};
		if (skip) return r;
		for (int k = 0; k < 3; k++) m[k] = c[k] < 0 ? -c[k] : c[k];
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		while (mx >= 64'd1 << 30) begin
			for (int k = 0; k < 3; k++) m[k] >>= 1;
			mx >>= 1;
		end
		while (mx < 64'd1 << 29) begin
			for (int k = 0; k < 3; k++) m[k] <<= 1;
			mx <<= 1;
		end
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * 65536 + len / 2) / len;
			nn[k] = c[k] < 0 ? -int'(q) : int'(q);
		end
		dd = longint'(nn[0]) * ex + longint'(nn[1]) * ey + longint'(nn[2]) * ez;
		dd = (dd + 32768) >>> 16;
		if (dd > longint'(IMAX)) dd = IMAX;
		if (dd < longint'(IMIN)) dd = IMIN;
		r.nx = nn[0];
		r.ny = nn[1];
		r.nz = nn[2];
		r.d = int'(dd);
		return r;
	endfunction

	task automatic clip_predict(cmd_t cmd, int x, int y, int z, int w);
		clip_res_t out[$];
		clip_res_t r;
		bit any, skip;
		case (cmd)
			CMD_CLEAR: begin
				n_planes = 0;
				n_verts = 0;
			end
			CMD_LOAD_PLANE: begin
				if (n_planes < MAX_PLANES) begin
					frustum[n_planes] = '{x, y, z, w};
					n_planes++;
				end
			end
			CMD_LOAD_VERT: begin
				if (n_verts < MAX_VERTS) begin
					portal[n_verts] = '{x, y, z};
					n_verts++;
				end
			end
			default: begin
				n_runs++;
				for (int i = 0; i < n_planes; i++) begin
					any = 0;
					for (int j = 0; j < n_verts && !any; j++)
						if (vertex_inside(frustum[i], portal[j])) any = 1;
					if (!any) begin
						r = '{ST_REJECT, 0, 0, 0, 0, 0, 1};
						pending.insert(pending.size(), r);
						return;
					end
				end
				for (int i = 0; i < n_planes; i++) begin
					r = '{ST_PLANE, frustum[i].nx, frustum[i].ny, frustum[i].nz,
						frustum[i].d, 0, 0};
					out.insert(out.size(), r);
				end
				if (n_verts >= 3) begin
					for (int i = 0; i < n_verts && out.size() < MAX_PLANES; i++) begin
						r = side_plane(portal[i], portal[(i + 1) % n_verts], x, y, z, skip);
						if (!skip) out.insert(out.size(), r);
					end
				end
				if (out.size() == 0) begin
					r = '{ST_EMPTY, 0, 0, 0, 0, 0, 1};
					pending.insert(pending.size(), r);
					return;
				end
				out[out.size() - 1].last = 1;
				foreach (out[k]) pending.insert(pending.size(), out[k]);
			end
		endcase
	endtask

	task automatic send(cmd_t cmd, int x, int y, int z, int w, bit typed, status_t st);
		clip_res_t exp_res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {w, z, y, x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		if (typed) begin
			n_runs++;
			exp_res = '{st, 0, 0, 0, 0, 0, 1};
			pending.insert(pending.size(), exp_res);
		end else begin
			clip_predict(cmd, x, y, z, w);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		burst_left = 0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(cmd_t cmd, int x, int y, int z, int w, bit typed, status_t st);
		row_t row;
		row = '{cmd, x, y, z, w, typed, st};
		rows.insert(rows.size(), row);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return IMIN;
			1: return IMAX;
			2: return 0;
			3, 4, 5: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
			default: return int'($urandom);
		endcase
	endfunction

	task automatic random_job();
		int np, nv, runs, d;
		if ($urandom_range(0, 4) != 0) send(CMD_CLEAR, rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), 0, ST_PLANE);
		if ($urandom_range(0, 9) == 0)
			send(cmd_t'($urandom_range(0, 2)), int'($urandom), int'($urandom),
				int'($urandom), int'($urandom), 0, ST_PLANE);
		np = $urandom_range(0, 11) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 3);
		nv = $urandom_range(0, 11) == 0 ? $urandom_range(0, 36) :
			($urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6));
		for (int i = 0; i < np; i++) begin
			d = $urandom_range(0, 4) == 0 ? int'($urandom) :
				IMIN + int'($urandom_range(0, 1 << 24));
			send(CMD_LOAD_PLANE, rand_coord(), rand_coord(), rand_coord(), d, 0, ST_PLANE);
		end
		for (int i = 0; i < nv; i++)
			send(CMD_LOAD_VERT, rand_coord(), rand_coord(), rand_coord(), int'($urandom),
				0, ST_PLANE);
		runs = $urandom_range(1, 2);
		for (int i = 0; i < runs; i++)
			send(CMD_RUN, rand_coord(), rand_coord(), rand_coord(), int'($urandom), 0,
				ST_PLANE);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(5, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= $urandom_range(0, 7) == 0;
		endcase
	end

	always @(posedge clk) begin
		clip_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
			end else begin
				want = pending.pop_front();
				if (want.side) n_sides++;
				if (want.status == ST_REJECT) n_rejects++;
				if (want.status == ST_EMPTY) n_empty++;
				check_field("status", want.status, m_axis_tuser[1:0]);
				check_field("normal_x", want.nx, int'(m_axis_tdata[31:0]));
				check_field("normal_y", want.ny, int'(m_axis_tdata[63:32]));
				check_field("normal_z", want.nz, int'(m_axis_tdata[95:64]));
				check_field("out_offset", want.d, int'(m_axis_tdata[127:96]));
				check_field("is_side_plane", want.side, m_axis_tuser[2]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** portal_frustum_clip: FAILED **");
			$finish;
		end
	end

	initial begin
		add_row(CMD_RUN, 0, 0, 0, 0, 1, ST_EMPTY);
		add_row(CMD_LOAD_PLANE, 0, 0, ONE, 100 * ONE, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, 0, 0, 0, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, 0, 0, 0, 1, ST_REJECT);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, 0, 0, 0, 1, ST_EMPTY);
		add_row(CMD_LOAD_PLANE, 0, 0, ONE, -ONE, 0, ST_PLANE);
		add_row(CMD_RUN, ONE, ONE, ONE, 0, 1, ST_REJECT);
		add_row(CMD_LOAD_VERT, -ONE, -ONE, ONE, 0, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, ONE, -ONE, ONE, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, 0, 0, 0, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, 0, ONE, ONE, 0, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, 0, ONE, ONE, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, 0, 0, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, ONE, ONE, 0, 0, ST_PLANE);
		add_row(CMD_CLEAR, IMAX, IMIN, IMAX, IMIN, 0, ST_PLANE);
		add_row(CMD_LOAD_PLANE, IMAX, IMIN, IMAX, IMIN, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, IMAX, IMAX, IMAX, IMAX, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, IMIN, IMIN, IMIN, IMIN, 0, ST_PLANE);
		add_row(CMD_LOAD_VERT, IMAX, IMIN, 0, 0, 0, ST_PLANE);
		add_row(CMD_RUN, IMIN, IMAX, IMIN, 0, 0, ST_PLANE);
		add_row(CMD_RUN, 0, 0, 0, IMAX, 0, ST_PLANE);
		add_row(CMD_RUN, IMAX, IMAX, IMAX, 0, 0, ST_PLANE);

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].z, rows[i].w, rows[i].typed,
				rows[i].st);
		drain();
		while (sent < ITEM_GOAL) begin
			random_job();
			if (sent > ITEM_GOAL / 2 && sent < ITEM_GOAL / 2 + 20) drain();
		end
		drain();
		repeat (300) @(posedge clk);
		$display("Covered %0d requests with %0d runs: %0d results, %0d side planes,",
			sent, n_runs, n_results, n_sides);
		$display("%0d rejected portals and %0d empty frustums.", n_rejects, n_empty);
		if (errors == 0 && pending.size() == 0) begin
			$display("** portal_frustum_clip: PASSED **");
		end else begin
			$display("** portal_frustum_clip: FAILED **");
		end
		$finish;
	end
endmodule
